// ----- hdl/lams_pkg.sv -----
// Shared types and constants for the local alignment max score block.
`default_nettype none
package lams_pkg;

    // One input beat.
    typedef struct packed {
        logic       cmd;
        logic [7:0] position;
        logic [1:0] base;
        logic       last;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [14:0] max_score;
        logic [6:0]  best_row;
        logic [7:0]  best_col;
    } result_t;

    // Scoring registers as seen by the datapath.
    typedef struct packed {
        logic [3:0]        match_score;
        logic signed [4:0] mismatch_score;
        logic signed [4:0] gap_score;
    } cfg_t;

    // Classified operation held in the queue between front and back.
    typedef struct packed {
        logic       is_ref;
        logic       store_en;
        logic [7:0] position;
        logic [1:0] base;
        logic       last;
    } op_t;

    // Queue handshake toward the back end.
    typedef struct packed {
        logic valid;
        op_t  op;
    } queue_out_t;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_REF   = 1'b1;

    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    localparam int          SCORE_W   = 16;
    localparam logic [14:0] SCORE_SAT = 15'h7fff;

endpackage
`default_nettype wire

// ----- hdl/local_alignment_max_score.sv -----
// Top level: scoring registers, front end queue and alignment back end.
// Loading: one base beat per cycle; the front queue holds two beats, busy while it is full.
// A run steps, per stripe of up to PE_COUNT columns, through load, fill, scan and merge states;
// a result state ends it.
// The result strobe lasts one cycle and cannot be held off by the receiver.
// Reset is asynchronous and active low; it restores the scoring registers, stores stay undefined.
`default_nettype none
module local_alignment_max_score
    import lams_pkg::*;
#(
    parameter int QUERY_LEN = 128,
    parameter int REF_LEN   = 256,
    parameter int PE_COUNT  = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire item_t      item,
    output logic            busy,
    output result_t         result,
    output logic            result_valid,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [4:0] cfg_data
);

    cfg_t       cfg_reg;
    queue_out_t q_out;
    logic       q_pop;

    assign cfg_ready = 1'b1;

    // Scoring register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_score    <= 4'd2;
            cfg_reg.mismatch_score <= -5'sd1;
            cfg_reg.gap_score      <= -5'sd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MATCH:    cfg_reg.match_score    <= cfg_data[3:0];
                REG_MISMATCH: cfg_reg.mismatch_score <= $signed(cfg_data);
                REG_GAP:      cfg_reg.gap_score      <= $signed(cfg_data);
                default:      ;
            endcase
        end
    end

    lams_front #(
        .QUERY_LEN (QUERY_LEN),
        .REF_LEN   (REF_LEN)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .q_out (q_out),
        .q_pop (q_pop)
    );

    lams_back #(
        .QUERY_LEN (QUERY_LEN),
        .REF_LEN   (REF_LEN),
        .PE_COUNT  (PE_COUNT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_out        (q_out),
        .q_pop        (q_pop),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
`default_nettype wire

// ----- hdl/lams_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none
module lams_front
    import lams_pkg::*;
#(
    parameter int QUERY_LEN = 128,
    parameter int REF_LEN   = 256
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire item_t item,
    output logic       busy,
    output queue_out_t q_out,
    input  wire logic  q_pop
);

    op_t        op_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    op_t        op_new;

    // Classify the beat: sequence select and range check.
    always_comb
    begin
        op_new.is_ref   = (item.cmd == CMD_REF);
        op_new.position = item.position;
        op_new.base     = item.base;
        op_new.last     = item.last;
        if (item.cmd == CMD_REF)
        begin
            op_new.store_en = (int'(item.position) < REF_LEN);
        end
        else
        begin
            op_new.store_en = (int'(item.position) < QUERY_LEN);
        end
    end

    assign busy        = (count_reg == 2'd2);
    assign push        = start && !busy;
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.op    = op_reg[rd_ptr_reg];

    // Two-entry queue pointers.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_reg[wr_ptr_reg] <= op_new;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/lams_back.sv -----
// Back end: sequence stores, systolic stripe of cells and best-cell tracking.
`default_nettype none
module lams_back
    import lams_pkg::*;
#(
    parameter int QUERY_LEN = 128,
    parameter int REF_LEN   = 256,
    parameter int PE_COUNT  = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire queue_out_t q_out,
    output logic            q_pop,
    output result_t         result,
    output logic            result_valid
);

    localparam int QA_W = (QUERY_LEN > 1) ? $clog2(QUERY_LEN) : 1;
    localparam int RA_W = (REF_LEN > 1) ? $clog2(REF_LEN) : 1;
    localparam int PI_W = (PE_COUNT > 1) ? $clog2(PE_COUNT) : 1;
    localparam int K_W  = $clog2(PE_COUNT + 1);
    localparam int T_W  = $clog2(QUERY_LEN + PE_COUNT + 1);
    localparam int C_W  = $clog2(REF_LEN + PE_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_FILL, S_SCAN, S_MERGE, S_DONE
    } state_t;

    state_t state_reg;

    // Stores.
    logic [1:0]         qmem [QUERY_LEN];
    logic [1:0]         rmem [REF_LEN];
    logic [SCORE_W-1:0] bmem [QUERY_LEN];
    logic [1:0]         q_rd_reg;
    logic [1:0]         r_rd_reg;
    logic [SCORE_W-1:0] b_rd_reg;

    // Sequencer.
    logic [C_W-1:0] base_col_reg;
    logic [K_W-1:0] k_reg;
    logic [T_W-1:0] t_reg;
    logic [K_W-1:0] width_reg;

    // Cell array.
    logic [1:0]         ref_base_reg [PE_COUNT];
    logic [SCORE_W-1:0] h_reg        [PE_COUNT];
    logic [SCORE_W-1:0] lp_reg       [PE_COUNT];
    logic [1:0]         qb_reg       [PE_COUNT];
    logic [QA_W-1:0]    row_reg      [PE_COUNT];
    logic [PE_COUNT-1:0] act_reg;
    logic signed [SCORE_W:0] pbest_reg [PE_COUNT];
    logic [QA_W-1:0]    pbrow_reg    [PE_COUNT];

    // Stripe and run best.
    logic signed [SCORE_W:0] sb_score_reg;
    logic [QA_W-1:0]         sb_row_reg;
    logic [PI_W-1:0]         sb_col_reg;
    logic signed [SCORE_W:0] gb_score_reg;
    logic [QA_W-1:0]         gb_row_reg;
    logic [C_W-1:0]          gb_col_reg;

    logic [31:0]        rem_w;
    logic [K_W-1:0]     width_w;
    logic [31:0]        rcol_w;
    logic [RA_W-1:0]    r_addr;
    logic [31:0]        row_w;
    logic [QA_W-1:0]    row_addr;
    logic [PI_W-1:0]    last_pe;
    logic [PI_W-1:0]    scan_idx;
    logic signed [SCORE_W:0] cand;
    logic [31:0]        next_col_w;

    logic [PE_COUNT-1:0] in_act;
    logic [1:0]          in_q    [PE_COUNT];
    logic [SCORE_W-1:0]  in_left [PE_COUNT];
    logic [QA_W-1:0]     in_row  [PE_COUNT];
    logic [SCORE_W-1:0]  h_new   [PE_COUNT];
    logic [PE_COUNT-1:0] in_stripe;

    assign q_pop = (state_reg == S_IDLE) && q_out.valid;

    // Stripe width and memory read addresses.
    always_comb
    begin
        rem_w      = 32'(REF_LEN) - 32'(base_col_reg);
        width_w    = (rem_w > 32'(PE_COUNT)) ? K_W'(PE_COUNT) : K_W'(rem_w);
        rcol_w     = 32'(base_col_reg) + 32'(k_reg);
        r_addr     = (rcol_w < 32'(REF_LEN)) ? RA_W'(rcol_w) : '0;
        row_w      = (state_reg == S_FILL) ? 32'(t_reg) + 32'd1 : 32'd0;
        row_addr   = (row_w < 32'(QUERY_LEN)) ? QA_W'(row_w) : '0;
        last_pe    = PI_W'(width_reg - K_W'(1));
        scan_idx   = k_reg[PI_W-1:0];
        cand       = pbest_reg[scan_idx];
        next_col_w = 32'(base_col_reg) + 32'(PE_COUNT);
    end

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (q_pop && q_out.op.store_en && !q_out.op.is_ref)
        begin
            qmem[QA_W'(q_out.op.position)] <= q_out.op.base;
        end
        if (q_pop && q_out.op.store_en && q_out.op.is_ref)
        begin
            rmem[RA_W'(q_out.op.position)] <= q_out.op.base;
        end
        if ((state_reg == S_FILL) && act_reg[last_pe])
        begin
            bmem[row_reg[last_pe]] <= h_reg[last_pe];
        end
        q_rd_reg <= qmem[row_addr];
        b_rd_reg <= bmem[row_addr];
        r_rd_reg <= rmem[r_addr];
    end

    // Cell datapath: during the fill each cell scores one row per cycle, one row behind its west neighbor.
    genvar gi;
    generate
        for (gi = 0; gi < PE_COUNT; gi++)
        begin : g_cell
            logic signed [SCORE_W+1:0] sc, gp, d, l, u, m;

            if (gi == 0)
            begin : g_first
                assign in_act[gi]  = (state_reg == S_FILL) && (32'(t_reg) < 32'(QUERY_LEN));
                assign in_q[gi]    = q_rd_reg;
                assign in_left[gi] = (base_col_reg == '0) ? '0 : b_rd_reg;
                assign in_row[gi]  = QA_W'(t_reg);
            end
            else
            begin : g_rest
                assign in_act[gi]  = act_reg[gi-1];
                assign in_q[gi]    = qb_reg[gi-1];
                assign in_left[gi] = h_reg[gi-1];
                assign in_row[gi]  = row_reg[gi-1];
            end

            assign in_stripe[gi] = (K_W'(gi) < width_reg);

            always_comb
            begin
                if (in_q[gi] == ref_base_reg[gi])
                begin
                    sc = $signed({{(SCORE_W-2){1'b0}}, cfg.match_score});
                end
                else
                begin
                    sc = $signed({{(SCORE_W-3){cfg.mismatch_score[4]}}, cfg.mismatch_score});
                end
                gp = $signed({{(SCORE_W-3){cfg.gap_score[4]}}, cfg.gap_score});
                d  = $signed({2'b00, lp_reg[gi]}) + sc;
                l  = $signed({2'b00, in_left[gi]}) + gp;
                u  = $signed({2'b00, h_reg[gi]}) + gp;
                m  = '0;
                if (d > m)
                begin
                    m = d;
                end
                if (l > m)
                begin
                    m = l;
                end
                if (u > m)
                begin
                    m = u;
                end
                h_new[gi] = m[SCORE_W-1:0];
            end

            // Cell registers: reset and loaded with reference bases while the stripe loads, advanced during the fill.
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    act_reg[gi] <= 1'b0;
                end
                else if (state_reg == S_LOAD)
                begin
                    act_reg[gi] <= 1'b0;
                end
                else if (state_reg == S_FILL)
                begin
                    act_reg[gi] <= in_act[gi];
                end
            end

            always_ff @(posedge clk)
            begin
                if (state_reg == S_LOAD)
                begin
                    h_reg[gi]     <= '0;
                    lp_reg[gi]    <= '0;
                    pbest_reg[gi] <= -(SCORE_W+1)'(1);
                    if (k_reg != '0)
                    begin
                        if (gi == PE_COUNT - 1)
                        begin
                            ref_base_reg[gi] <= r_rd_reg;
                        end
                        else
                        begin
                            ref_base_reg[gi] <= ref_base_reg[(gi + 1) % PE_COUNT];
                        end
                    end
                end
                else if ((state_reg == S_FILL) && in_act[gi])
                begin
                    h_reg[gi]   <= h_new[gi];
                    lp_reg[gi]  <= in_left[gi];
                    qb_reg[gi]  <= in_q[gi];
                    row_reg[gi] <= in_row[gi];
                    if (in_stripe[gi] && ($signed({1'b0, h_new[gi]}) > pbest_reg[gi]))
                    begin
                        pbest_reg[gi] <= $signed({1'b0, h_new[gi]});
                        pbrow_reg[gi] <= in_row[gi];
                    end
                end
            end
        end
    endgenerate

    // Run sequencer with best-cell merge and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            base_col_reg <= '0;
            k_reg        <= '0;
            t_reg        <= '0;
            width_reg    <= '0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_out.op.last)
                    begin
                        gb_score_reg <= -(SCORE_W+1)'(1);
                        gb_row_reg   <= '0;
                        gb_col_reg   <= '0;
                        base_col_reg <= '0;
                        k_reg        <= '0;
                        state_reg    <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    width_reg <= width_w;
                    if (k_reg == K_W'(PE_COUNT))
                    begin
                        t_reg     <= '0;
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        k_reg <= k_reg + K_W'(1);
                    end
                end
                S_FILL:
                begin
                    if (32'(t_reg) == 32'(QUERY_LEN) + 32'(width_reg) - 32'd1)
                    begin
                        k_reg     <= '0;
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        t_reg <= t_reg + T_W'(1);
                    end
                end
                S_SCAN:
                begin
                    if ((k_reg == '0) || (cand > sb_score_reg) ||
                        ((cand == sb_score_reg) && (pbrow_reg[scan_idx] < sb_row_reg)))
                    begin
                        sb_score_reg <= cand;
                        sb_row_reg   <= pbrow_reg[scan_idx];
                        sb_col_reg   <= scan_idx;
                    end
                    if (k_reg == width_reg - K_W'(1))
                    begin
                        state_reg <= S_MERGE;
                    end
                    else
                    begin
                        k_reg <= k_reg + K_W'(1);
                    end
                end
                S_MERGE:
                begin
                    if (sb_score_reg > gb_score_reg)
                    begin
                        gb_score_reg <= sb_score_reg;
                        gb_row_reg   <= sb_row_reg;
                        gb_col_reg   <= base_col_reg + C_W'(sb_col_reg);
                    end
                    base_col_reg <= C_W'(next_col_w);
                    k_reg        <= '0;
                    if (next_col_w >= 32'(REF_LEN))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_DONE:
                begin
                    result_valid <= 1'b1;
                    if (gb_score_reg < 0)
                    begin
                        result.max_score <= '0;
                    end
                    else if (gb_score_reg > $signed({2'b00, SCORE_SAT}))
                    begin
                        result.max_score <= SCORE_SAT;
                    end
                    else
                    begin
                        result.max_score <= gb_score_reg[14:0];
                    end
                    result.best_row <= 7'(gb_row_reg);
                    result.best_col <= 8'(gb_col_reg);
                    state_reg       <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
